// ===== rtl/core/slide_gesture_detector_assert.svh =====
// Assertion macros for the slide gesture detector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SLIDE_GESTURE_DETECTOR_ASSERT_SVH
`define SLIDE_GESTURE_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define SGD_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sgd check failed");

`define SGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgd check failed");

`else

`define SGD_ASSERT(label, clk, rst_n, expr)

`define SGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sgd_pkg.sv =====
// Shared types and constants for the slide gesture detector.
// No dependencies; used by sgd_step and slide_gesture_detector.
package sgd_pkg;

    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_VEL_THRESHOLD = 3'd0,
        REG_POS_THRESHOLD = 3'd1,
        REG_NEG_THRESHOLD = 3'd2,
        REG_PEAK_WINDOW   = 3'd3,
        REG_FILTER_GAIN   = 3'd4
    } sgd_reg_idx_t;

    localparam logic [15:0] VEL_THRESHOLD_RST = 16'd1638;
    localparam logic [15:0] POS_THRESHOLD_RST = 16'd205;
    localparam logic [15:0] NEG_THRESHOLD_RST = 16'hFF33;
    localparam logic [15:0] PEAK_WINDOW_RST   = 16'd1600;
    localparam logic [12:0] FILTER_GAIN_RST   = 13'd3686;

    localparam logic [1:0] GESTURE_NONE = 2'b00;
    localparam logic [1:0] GESTURE_POS  = 2'b01;
    localparam logic [1:0] GESTURE_NEG  = 2'b11;

    localparam logic [31:0] TIME_NONE = 32'd0;

    typedef struct packed {
        logic [15:0] vel_threshold;
        logic [15:0] pos_threshold;
        logic [15:0] neg_threshold;
        logic [15:0] peak_window;
        logic [12:0] filter_gain;
    } sgd_cfg_t;

    typedef struct packed {
        logic [15:0] filtered_position;
        logic [15:0] prev_velocity;
        logic        rise_seen;
        logic [31:0] pos_cross_time;
        logic [31:0] neg_cross_time;
        logic [31:0] pulse_time;
    } sgd_state_t;

endpackage

// ===== rtl/core/sgd_step.sv =====
// Per-sample update: filter, threshold crossings, velocity pulse and pairing.
// Purely combinational; depends on sgd_pkg.
module sgd_step
    import sgd_pkg::*;
(
    input  sgd_cfg_t    cfg,
    input  sgd_state_t  st,
    input  logic [15:0] position,
    input  logic [15:0] velocity,
    input  logic [31:0] timestamp,
    output sgd_state_t  st_next,
    output logic [1:0]  gesture
);

    logic signed [16:0] diff;
    logic signed [30:0] prod;
    logic signed [18:0] delta;
    logic signed [19:0] lp_sum;
    logic [15:0]        lp_new;
    logic               rise;
    logic               fell;
    logic               up_cross;
    logic               down_cross;
    logic               ts_ok;
    logic [31:0]        pos_t;
    logic [31:0]        neg_t;
    logic [31:0]        pulse_t;
    logic signed [32:0] gap_pos;
    logic signed [32:0] gap_neg;
    logic signed [32:0] window;

    always_comb
    begin
        diff   = $signed({position[15], position})
               - $signed({st.filtered_position[15], st.filtered_position});
        prod   = $signed({1'b0, cfg.filter_gain}) * diff;
        // arithmetic shift gives floor division by 4096
        delta  = prod[30:12];
        lp_sum = $signed({{4{st.filtered_position[15]}}, st.filtered_position})
               + $signed({delta[18], delta});
        if (lp_sum > 20'sd32767)
        begin
            lp_new = 16'h7FFF;
        end
        else if (lp_sum < -20'sd32768)
        begin
            lp_new = 16'h8000;
        end
        else
        begin
            lp_new = lp_sum[15:0];
        end

        rise = ($signed(st.prev_velocity) < $signed(cfg.vel_threshold))
            && ($signed(velocity) >= $signed(cfg.vel_threshold));
        fell = st.rise_seen
            && ($signed(st.prev_velocity) >= $signed(cfg.vel_threshold))
            && ($signed(velocity) < $signed(cfg.vel_threshold));

        up_cross   = ($signed(st.filtered_position) < $signed(cfg.pos_threshold))
                  && ($signed(lp_new) >= $signed(cfg.pos_threshold));
        down_cross = ($signed(st.filtered_position) >= $signed(cfg.neg_threshold))
                  && ($signed(lp_new) < $signed(cfg.neg_threshold));

        ts_ok   = (timestamp != TIME_NONE);
        pos_t   = (up_cross && ts_ok) ? timestamp : st.pos_cross_time;
        neg_t   = (down_cross && ts_ok) ? timestamp : st.neg_cross_time;
        pulse_t = (fell && ts_ok) ? timestamp : st.pulse_time;

        gap_pos = $signed({1'b0, pulse_t}) - $signed({1'b0, pos_t});
        gap_neg = $signed({1'b0, pulse_t}) - $signed({1'b0, neg_t});
        window  = $signed({17'd0, cfg.peak_window});

        st_next.filtered_position = lp_new;
        st_next.prev_velocity     = velocity;
        st_next.rise_seen         = (st.rise_seen || rise) && !fell;
        st_next.pos_cross_time    = pos_t;
        st_next.neg_cross_time    = neg_t;
        st_next.pulse_time        = pulse_t;
        gesture                   = GESTURE_NONE;

        priority if (pulse_t != TIME_NONE && pos_t != TIME_NONE)
        begin
            if (gap_pos <= window)
            begin
                gesture = GESTURE_POS;
            end
            st_next.pos_cross_time = TIME_NONE;
            st_next.pulse_time     = TIME_NONE;
        end
        else if (pulse_t != TIME_NONE && neg_t != TIME_NONE)
        begin
            if (gap_neg <= window)
            begin
                gesture = GESTURE_NEG;
            end
            st_next.neg_cross_time = TIME_NONE;
            st_next.pulse_time     = TIME_NONE;
        end
        else
        begin
            gesture = GESTURE_NONE;
        end
    end

endmodule

// ===== rtl/core/slide_gesture_detector.sv =====
// Slide gesture detector: top level with sample register, state and result register.
// Depends on sgd_pkg, sgd_step and slide_gesture_detector_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per sensor sample:
//   position, velocity (Q4.12 signed) and timestamp (ticks, 0 = never stored).
//   Output channel (out_valid/out_ready) returns exactly one word per sample:
//   gesture = +1 positive-side slide, -1 negative-side slide, 0 none.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one of the
//   five registers; cfg_ready is always high, unknown indexes are dropped.
//   Write config only while no sample is in flight.
//   A sample accepted into the sample register moves to the result register
//   when the output is free. Throughput: one sample per cycle while out_ready
//   is high; the sample register feeds the filter multiply, compares and
//   pairing logic, which update state and the result register together.
//   Reset clears the filter, velocity history and stored event times and
//   loads the default register values. When out_ready stays low, the result
//   and one further sample are held, then in_ready drops; nothing is lost.
module slide_gesture_detector
    import sgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      position,
    input  logic [15:0]      velocity,
    input  logic [31:0]      timestamp,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       gesture,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [15:0]      cfg_data
);

`include "slide_gesture_detector_assert.svh"

    sgd_cfg_t    cfg_reg;
    sgd_state_t  st_reg;
    sgd_state_t  st_next;
    logic        s1_valid_reg;
    logic [15:0] pos_reg;
    logic [15:0] vel_reg;
    logic [31:0] ts_reg;
    logic        out_valid_reg;
    logic [1:0]  gesture_reg;
    logic [1:0]  gesture_next;
    logic        advance;
    logic        cfg_we;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;

    sgd_step u_step (
        .cfg       (cfg_reg),
        .st        (st_reg),
        .position  (pos_reg),
        .velocity  (vel_reg),
        .timestamp (ts_reg),
        .st_next   (st_next),
        .gesture   (gesture_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vel_threshold <= VEL_THRESHOLD_RST;
            cfg_reg.pos_threshold <= POS_THRESHOLD_RST;
            cfg_reg.neg_threshold <= NEG_THRESHOLD_RST;
            cfg_reg.peak_window   <= PEAK_WINDOW_RST;
            cfg_reg.filter_gain   <= FILTER_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VEL_THRESHOLD: cfg_reg.vel_threshold <= cfg_data;
                REG_POS_THRESHOLD: cfg_reg.pos_threshold <= cfg_data;
                REG_NEG_THRESHOLD: cfg_reg.neg_threshold <= cfg_data;
                REG_PEAK_WINDOW:   cfg_reg.peak_window   <= cfg_data;
                REG_FILTER_GAIN:   cfg_reg.filter_gain   <= cfg_data[12:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pos_reg <= position;
            vel_reg <= velocity;
            ts_reg  <= timestamp;
        end
        if (advance)
        begin
            gesture_reg <= gesture_next;
        end
    end

    // pairing always consumes a stored pulse when any crossing is stored
    `SGD_ASSERT(a_pair_cleared, clk, rst_n,
        !(st_reg.pulse_time != TIME_NONE
          && (st_reg.pos_cross_time != TIME_NONE || st_reg.neg_cross_time != TIME_NONE)))
    `SGD_ASSERT(a_gesture_code, clk, rst_n,
        !out_valid_reg || gesture_reg != 2'b10)
    `SGD_ASSERT_NEXT(a_state_hold, clk, rst_n,
        !advance, $stable(st_reg))

endmodule
